// ===== rtl/core/mwm_pkg.sv =====
// shared types and constants of the mecanum wheel mixer
`timescale 1ns / 1ps

package mwm_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CMD_W   = 8;
    localparam int CAP_W   = 7;
    localparam int SUM_W   = 10;
    localparam int ABS_W   = 9;
    localparam int SQ_W    = 15;
    localparam int TABS_W  = 7;
    localparam int POWER_W = 16;
    localparam int NUM_WHEELS = 4;

    localparam logic signed [CMD_W-1:0] CMD_LIMIT = 8'sd100;
    localparam logic [CAP_W-1:0]        CAP_RESET = 7'd100;

    // wheel order inside the sum array and the output word
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_RL = 2;
    localparam int WHEEL_RR = 3;

    typedef struct packed {
        logic                             stop;
        logic [NUM_WHEELS-1:0][SUM_W-1:0] sum;
        logic [ABS_W-1:0]                 maxabs;
        logic [SQ_W-1:0]                  sq;
        logic [TABS_W-1:0]                tabs;
    } t_front_item;

endpackage

// ===== rtl/core/mwm_front.sv =====
// front stage: clamps the commands and forms sums, largest absolute sum, squared radius and absolute turn
`timescale 1ns / 1ps

module mwm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [23:0]           i_tdata,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mwm_pkg::t_front_item  o_item
);
    import mwm_pkg::*;

    function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] raw);
        logic signed [CMD_W-1:0] v;
        v = raw;
        if (raw > CMD_LIMIT) begin
            v = CMD_LIMIT;
        end else if (raw < -CMD_LIMIT) begin
            v = -CMD_LIMIT;
        end
        return v;
    endfunction

    function automatic logic [TABS_W-1:0] abs_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] a;
        a = (v < 0) ? -v : v;
        return TABS_W'(a);
    endfunction

    function automatic logic [ABS_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] a;
        a = (v < 0) ? -v : v;
        return ABS_W'(a);
    endfunction

    logic                    r_valid;
    t_front_item             r_item;
    t_front_item             n_item;

    logic signed [CMD_W-1:0] d;
    logic signed [CMD_W-1:0] s;
    logic signed [CMD_W-1:0] t;
    logic signed [SUM_W-1:0] de;
    logic signed [SUM_W-1:0] se;
    logic signed [SUM_W-1:0] te;
    logic signed [SUM_W-1:0] sums [NUM_WHEELS];
    logic [ABS_W-1:0]        abss [NUM_WHEELS];
    logic [ABS_W-1:0]        max01;
    logic [ABS_W-1:0]        max23;
    logic [TABS_W-1:0]       dabs;
    logic [TABS_W-1:0]       sabs;

    assign d  = clamp_cmd(i_tdata[7:0]);
    assign s  = clamp_cmd(i_tdata[15:8]);
    assign t  = clamp_cmd(i_tdata[23:16]);
    assign de = SUM_W'(d);
    assign se = SUM_W'(s);
    assign te = SUM_W'(t);

    assign sums[WHEEL_FL] = de + se + te;
    assign sums[WHEEL_FR] = de - se - te;
    assign sums[WHEEL_RL] = de - se + te;
    assign sums[WHEEL_RR] = de + se - te;

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            abss[k] = abs_sum(sums[k]);
        end
    end

    assign max01 = (abss[0] > abss[1]) ? abss[0] : abss[1];
    assign max23 = (abss[2] > abss[3]) ? abss[2] : abss[3];
    assign dabs  = abs_cmd(d);
    assign sabs  = abs_cmd(s);

    always_comb begin
        n_item.stop   = (d == 0) && (s == 0) && (t == 0);
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_item.sum[k] = sums[k];
        end
        n_item.maxabs = (max01 > max23) ? max01 : max23;
        n_item.sq     = SQ_W'(dabs * dabs) + SQ_W'(sabs * sabs);
        n_item.tabs   = abs_cmd(t);
    end

    assign o_tready = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_tvalid && o_tready) begin
                r_valid <= 1'b1;
                r_item  <= n_item;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/mwm_queue.sv =====
// short queue of classified items between the front and back parts
`timescale 1ns / 1ps

module mwm_queue #(
    parameter int DEPTH = mwm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_ready,
    input  mwm_pkg::t_front_item  i_item,
    output logic                  o_valid,
    input  logic                  i_pop,
    output mwm_pkg::t_front_item  o_item
);
    import mwm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_front_item      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/mwm_back.sv =====
// back engine: square root, magnitude, four scaling divider lanes and output register
`timescale 1ns / 1ps

module mwm_back #(
    parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mwm_pkg::CAP_W-1:0]    i_power_cap,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  mwm_pkg::t_front_item         i_item,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [63:0]                  o_tdata,
    output logic                         o_tuser
);
    import mwm_pkg::*;

    localparam int RW   = 8 + FRAC_BITS;          // root width
    localparam int XW   = 2 * RW;                 // radicand width
    localparam int REMW = RW + 2;                 // root remainder width
    localparam int MW   = CAP_W + FRAC_BITS;      // magnitude width
    localparam int QW   = MW;                     // quotient width
    localparam int PW   = ABS_W + MW;             // product width
    localparam int DW   = ABS_W + 1;              // divisor width
    localparam int NW   = PW + 1;                 // dividend width, equals QW + DW
    localparam int CW   = $clog2(RW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_MAG,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    t_front_item        r_item;
    logic [CW-1:0]      r_cnt;
    logic [XW-1:0]      r_x;
    logic [REMW-1:0]    r_rrem;
    logic [RW-1:0]      r_root;
    logic [MW-1:0]      r_mag;
    logic [DW-1:0]      r_rem [NUM_WHEELS];
    logic [QW-1:0]      r_dvd [NUM_WHEELS];
    logic               r_out_valid;
    logic               r_out_stop;
    logic [63:0]        r_out_data;

    logic               out_free;
    logic               out_load;
    logic [REMW+1:0]    n_rtry;
    logic [REMW+1:0]    n_rtrial;
    logic               n_rbit;
    logic [RW:0]        n_msum;
    logic [MW-1:0]      n_cap;
    logic [MW-1:0]      n_mag;
    logic [DW-1:0]      n_div;
    logic [NW-1:0]      n_num  [NUM_WHEELS];
    logic [DW:0]        n_dtry [NUM_WHEELS];
    logic               n_dbit [NUM_WHEELS];
    logic [POWER_W-1:0] n_pw   [NUM_WHEELS];
    logic [63:0]        n_out;

    function automatic logic [ABS_W-1:0] abs_sum(input logic [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sv;
        sv = $signed(v);
        return ABS_W'((sv < 0) ? -sv : sv);
    endfunction

    assign out_free = !r_out_valid || i_tready;

    // one root bit per step, two radicand bits brought down
    assign n_rtry   = {r_rrem, r_x[XW-1:XW-2]};
    assign n_rtrial = (REMW+2)'({r_root, 2'b01});
    assign n_rbit   = (n_rtry >= n_rtrial);

    assign n_msum = (RW+1)'(r_root) + ((RW+1)'(r_item.tabs) << FRAC_BITS);
    assign n_cap  = MW'(i_power_cap) << FRAC_BITS;
    assign n_mag  = (n_msum < (RW+1)'(n_cap)) ? MW'(n_msum) : n_cap;
    assign n_div  = {r_item.maxabs, 1'b0};

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            // 2*|sum|*mag + maxabs, rounding offset for the half-up divide
            n_num[k]  = {PW'(abs_sum(r_item.sum[k])) * r_mag, 1'b0} + NW'(r_item.maxabs);
            n_dtry[k] = {r_rem[k], r_dvd[k][QW-1]};
            n_dbit[k] = (n_dtry[k] >= (DW+1)'(n_div));
        end
    end

    // sign and saturation of each quotient
    always_comb begin
        logic [31:0] q;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            q = 32'(r_dvd[k]);
            if (r_item.maxabs == '0) begin
                n_pw[k] = '0;
            end else if (r_item.sum[k][SUM_W-1]) begin
                n_pw[k] = (q >= 32'd32768) ? 16'h8000 : POWER_W'(-q);
            end else begin
                n_pw[k] = (q > 32'd32767) ? 16'h7FFF : POWER_W'(q);
            end
        end
        n_out = {n_pw[WHEEL_RR], n_pw[WHEEL_RL], n_pw[WHEEL_FR], n_pw[WHEEL_FL]};
    end

    assign o_pop    = (r_state == S_IDLE) && i_valid && (!i_item.stop || out_free);
    assign out_load = (o_pop && i_item.stop) || ((r_state == S_DONE) && out_free);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_item;
                        if (i_item.stop) begin
                            r_out_stop  <= 1'b1;
                            r_out_data  <= '0;
                        end else begin
                            r_x     <= XW'(i_item.sq) << (2 * FRAC_BITS);
                            r_rrem  <= '0;
                            r_root  <= '0;
                            r_cnt   <= CW'(RW - 1);
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    r_x    <= r_x << 2;
                    r_rrem <= n_rbit ? REMW'(n_rtry - n_rtrial) : REMW'(n_rtry);
                    r_root <= {r_root[RW-2:0], n_rbit};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_mag   <= n_mag;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    for (int k = 0; k < NUM_WHEELS; k++) begin
                        r_rem[k] <= n_num[k][NW-1:QW];
                        r_dvd[k] <= n_num[k][QW-1:0];
                    end
                    r_cnt   <= CW'(QW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int k = 0; k < NUM_WHEELS; k++) begin
                        r_rem[k] <= n_dbit[k] ? DW'(n_dtry[k] - (DW+1)'(n_div))
                                              : DW'(n_dtry[k]);
                        r_dvd[k] <= {r_dvd[k][QW-2:0], n_dbit[k]};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_stop  <= 1'b0;
                        r_out_data  <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while engine busy");

    a_mag_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mag <= n_cap))
        else $error("magnitude above power cap");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stop) |-> (r_out_data == '0))
        else $error("stop transaction with nonzero powers");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(QW - 1)))
        else $error("divider count out of range");

    a_root_to_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_cnt == '0) |=> (r_state == S_MAG))
        else $error("root did not hand over to magnitude");

endmodule

// ===== rtl/core/mecanum_wheel_mixer_top.sv =====
// Mecanum wheel mixer: turns drive, strafe and turn commands into four scaled
// wheel powers in signed Q.FRAC_BITS. The input stream accepts one transaction
// per cycle while the item queue (QUEUE_DEPTH entries plus one front register)
// has room. An all-zero command is loaded into the output register as soon as
// the back engine pops it and comes out with all powers zero and tuser set. The
// back engine takes one item at a time; any other item goes through these steps
// in order: pick-up, the bit-serial square root of drive^2+strafe^2, the
// magnitude clamp, the four multiplies, the four parallel one-bit-per-cycle
// rounding dividers, and the load of the output register once it is free. The
// power cap register is written with i_cfg_we and must only change while no
// item is in flight.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_top #(
    parameter int FRAC_BITS   = mwm_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = mwm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mwm_pkg::CAP_W-1:0] i_cfg_wdata,     // power_cap
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [23:0]               s_axis_tdata,    // drive_cmd, strafe_cmd, turn_cmd
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata,    // front_left, front_right,
                                                       // rear_left, rear_right power
    output logic                      m_axis_tuser     // stop_flag
);
    import mwm_pkg::*;

    logic [CAP_W-1:0] r_power_cap;
    logic             front_valid;
    logic             queue_ready;
    t_front_item      front_item;
    logic             queue_valid;
    logic             queue_pop;
    t_front_item      queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_power_cap <= i_cfg_wdata;
        end
    end

    mwm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .o_valid  (front_valid),
        .i_ready  (queue_ready),
        .o_item   (front_item)
    );

    mwm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_item  (queue_item)
    );

    mwm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_power_cap (r_power_cap),
        .i_valid     (queue_valid),
        .o_pop       (queue_pop),
        .i_item      (queue_item),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the mecanum wheel mixer top level
`timescale 1ns / 1ps

module tb_top;
    import mwm_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int DRAIN_CYC = 2 * FRAC + 24;
    localparam int HOLD_LEN  = 300;
    localparam int CYC_LIMIT = 500000;
    localparam logic [CMD_W-1:0] CMD_MAX = 8'd100;
    localparam logic [CMD_W-1:0] CMD_MIN = 8'd156;  // -100

    typedef struct packed {
        logic                               stop;
        logic [NUM_WHEELS-1:0][POWER_W-1:0] power;
    } t_wheel_set;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;
    logic              m_axis_tuser;

    t_wheel_set        pending_wheel_sets[$];
    logic [CAP_W-1:0]  cap_model;
    int                wheel_mismatches;
    int                cycle_count;
    bit                src_idle_en;
    bit                sink_idle_en;
    logic              hold_start;
    int                hold_count;

    mecanum_wheel_mixer_top #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic int clamp_cmd(logic [CMD_W-1:0] raw);
        int v;
        v = $signed(raw);
        if (v > 100) v = 100;
        if (v < -100) v = -100;
        return v;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint root;
        longint probe;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (longint'(1) << b);
            if (probe * probe <= x) root = probe;
        end
        return root;
    endfunction

    function automatic logic [POWER_W-1:0] scale_wheel(int sum, longint mag, longint peak);
        longint q;
        longint r;
        q = (2 * longint'(sum < 0 ? -sum : sum) * mag + peak) / (2 * peak);
        if (q > 32768) q = 32768;
        r = (sum < 0) ? -q : q;
        if (r > 32767) r = 32767;
        return r[POWER_W-1:0];
    endfunction

    function automatic t_wheel_set mix_wheels(logic [23:0] cmd, logic [CAP_W-1:0] cap);
        t_wheel_set res;
        int         d, s, t;
        int         sums[NUM_WHEELS];
        longint     peak, mag, lim;
        res = '0;
        d = clamp_cmd(cmd[7:0]);
        s = clamp_cmd(cmd[15:8]);
        t = clamp_cmd(cmd[23:16]);
        if (d == 0 && s == 0 && t == 0) begin
            res.stop = 1'b1;
            return res;
        end
        sums[WHEEL_FL] = d + s + t;
        sums[WHEEL_FR] = d - s - t;
        sums[WHEEL_RL] = d - s + t;
        sums[WHEEL_RR] = d + s - t;
        peak = 0;
        foreach (sums[k]) begin
            if (sums[k] > peak) peak = sums[k];
            if (-sums[k] > peak) peak = -sums[k];
        end
        mag = int_sqrt(longint'(d * d + s * s) << (2 * FRAC))
            + (longint'(t < 0 ? -t : t) << FRAC);
        lim = longint'(cap) << FRAC;
        if (mag > lim) mag = lim;
        for (int k = 0; k < NUM_WHEELS; k++)
            res.power[k] = (peak == 0) ? '0 : scale_wheel(sums[k], mag, peak);
        return res;
    endfunction

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        t_wheel_set want;
        t_wheel_set got;
        if (!i_rst_n) begin
            cap_model <= CAP_RESET;
        end else begin
            if (cfg_we) cap_model <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                pending_wheel_sets.push_back(mix_wheels(s_axis_tdata, cap_model));
            if (m_axis_tvalid && m_axis_tready) begin
                got.stop  = m_axis_tuser;
                got.power = m_axis_tdata;
                if (pending_wheel_sets.size() == 0) begin
                    wheel_mismatches++;
                    if (wheel_mismatches <= 10)
                        $display("unexpected result transaction: tdata=%h tuser=%b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_wheel_sets.pop_front();
                    if (want.power[WHEEL_FL] !== got.power[WHEEL_FL] ||
                        want.power[WHEEL_FR] !== got.power[WHEEL_FR] ||
                        want.power[WHEEL_RL] !== got.power[WHEEL_RL] ||
                        want.power[WHEEL_RR] !== got.power[WHEEL_RR] ||
                        want.stop !== got.stop) begin
                        wheel_mismatches++;
                        if (wheel_mismatches <= 10) begin
                            $display("mismatch: exp fl=%0d fr=%0d rl=%0d rr=%0d stop=%b",
                                     $signed(want.power[WHEEL_FL]),
                                     $signed(want.power[WHEEL_FR]),
                                     $signed(want.power[WHEEL_RL]),
                                     $signed(want.power[WHEEL_RR]), want.stop);
                            $display("          act fl=%0d fr=%0d rl=%0d rr=%0d stop=%b",
                                     $signed(got.power[WHEEL_FL]),
                                     $signed(got.power[WHEEL_FR]),
                                     $signed(got.power[WHEEL_RL]),
                                     $signed(got.power[WHEEL_RR]), got.stop);
                        end
                    end
                end
            end
        end
    end

    // ---------------- result sink ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_count    <= 0;
        end else if (hold_start) begin
            hold_count    <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_count != 0) begin
            hold_count    <= hold_count - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 26);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYC_LIMIT) begin
            $display("mecanum_wheel_mixer_top test failed");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    // leaves tvalid high after the transaction so back-to-back items need no toggle
    task automatic send_command(input logic [CMD_W-1:0] d, input logic [CMD_W-1:0] s,
                                input logic [CMD_W-1:0] t);
        while (src_idle_en && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, s, d};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drops tvalid and lets the monitor log the last accepted transaction before the queue is checked
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_wheel_sets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_power_cap(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] rand_cmd();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 25) return CMD_W'($urandom_range(255));
        if (pick < 33) return (pick % 2) ? CMD_MAX : CMD_MIN;
        return CMD_W'($urandom_range(200) - 100);
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 4) send_command('0, '0, '0);
            else send_command(rand_cmd(), rand_cmd(), rand_cmd());
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_command(8'd0,   8'd0,   8'd0);     // stop
        send_command(CMD_MAX, 8'd0,  8'd0);
        send_command(CMD_MIN, 8'd0,  8'd0);
        send_command(8'd0,   CMD_MAX, 8'd0);
        send_command(8'd0,   CMD_MIN, 8'd0);
        send_command(8'd0,   8'd0,   CMD_MAX);
        send_command(8'd0,   8'd0,   CMD_MIN);
        send_command(CMD_MAX, CMD_MAX, CMD_MAX);
        send_command(CMD_MIN, CMD_MIN, CMD_MIN);
        send_command(CMD_MAX, CMD_MIN, CMD_MAX);
        send_command(8'd127, 8'd128, 8'd0);     // out of range, saturates
        send_command(8'd128, 8'd128, 8'd128);
        send_command(8'd155, 8'd101, 8'd127);
        send_command(8'd1,   8'd0,   8'd0);
        send_command(8'd0,   8'd255, 8'd0);
        send_command(8'd0,   8'd0,   8'd1);
        send_command(8'd3,   8'd4,   8'd0);     // exact root
        send_command(8'd255, 8'd255, 8'd255);
        send_command(8'd1,   8'd1,   8'd0);
        send_command(8'd10,  8'd20,  8'd246);
        send_command(8'd0,   8'd0,   8'd0);
        wait_idle();
    endtask

    task automatic test_cap_extremes();
        logic [CAP_W-1:0] caps[4];
        caps[0] = 7'd1;
        caps[1] = 7'd127;
        caps[2] = 7'd0;   // zero cap, all powers zero without stop
        caps[3] = CAP_W'($urandom_range(126) + 1);
        foreach (caps[i]) begin
            write_power_cap(caps[i]);
            send_command(CMD_MAX, CMD_MAX, CMD_MAX);
            send_command(8'd0, 8'd0, 8'd0);
            send_random(13);
        end
        wait_idle();
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++) begin
            write_power_cap(CAP_W'($urandom_range(126) + 1));
            // second phase runs with no idling on either side
            src_idle_en   = (phase != 1);
            sink_idle_en <= (phase != 1);
            send_random(200);
        end
        src_idle_en   = 1'b1;
        sink_idle_en <= 1'b1;
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_power_cap(CAP_RESET);
        src_idle_en = 1'b0;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        send_random(30);
        src_idle_en = 1'b1;
        wait_idle();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        m_axis_tready    = 1'b0;
        hold_start       = 1'b0;
        cycle_count      = 0;
        wheel_mismatches = 0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_cap_extremes();
        test_random_mix();
        test_backpressure();

        wait_idle();
        if (wheel_mismatches == 0 && pending_wheel_sets.size() == 0)
            $display("mecanum_wheel_mixer_top test passed");
        else
            $display("mecanum_wheel_mixer_top test failed");
        $finish;
    end

endmodule
